FILE: rtl/core/range_image_outlier_filter_macros.svh
// ----------------------------------------------------------------------------
// Range image outlier filter: assertion macros
// Shared helpers that wrap concurrent assertions on clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef RANGE_IMAGE_OUTLIER_FILTER_MACROS_SVH
`define RANGE_IMAGE_OUTLIER_FILTER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define RIF_ASSERT_NEVER(lbl, prop, msg) `RIF_ASSERT(lbl, !(prop), msg)

`endif

FILE: rtl/core/rif_pkg.sv
// ----------------------------------------------------------------------------
// rif_pkg
// Types, codes and window tables shared by the outlier filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rif_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEVEL  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  // Input command codes carried in tuser.
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Smallest image dimension that is filtered at all.
  localparam logic [10:0] MIN_DIM = 11'd11;

  // Effective configuration handed from the front to the back.
  typedef struct packed {
    logic [2:0]  level;
    logic [10:0] width;
    logic [10:0] height;
  } rif_cfg_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENT,
    ST_DIV,
    ST_PREP,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } rif_state_e;

  // Window edge length per level.
  function automatic logic [3:0] win_size(input logic [2:0] level);
    logic [3:0] ws;
    case (level)
      3'd1:    ws = 4'd3;
      3'd2:    ws = 4'd5;
      3'd3:    ws = 4'd6;
      3'd4:    ws = 4'd7;
      3'd5:    ws = 4'd9;
      default: ws = 4'd0;
    endcase
    return ws;
  endfunction

  // Minimum number of close neighbors per level.
  function automatic logic [6:0] min_count(input logic [2:0] level);
    logic [6:0] mc;
    case (level)
      3'd1:    mc = 7'd3;
      3'd2:    mc = 7'd5;
      3'd3:    mc = 7'd5;
      3'd4:    mc = 7'd7;
      3'd5:    mc = 7'd11;
      default: mc = 7'd0;
    endcase
    return mc;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rif_ram.sv
// ----------------------------------------------------------------------------
// rif_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rif_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 9232,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/rif_queue.sv
// ----------------------------------------------------------------------------
// rif_queue
// Two-entry job queue between the front and the back of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

module rif_queue #(
  parameter int unsigned Width = 36
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rif_front.sv
// ----------------------------------------------------------------------------
// rif_front
// Accepts samples and drains, holds configuration, writes the line store and
// queues one job for every result that is due.
// ----------------------------------------------------------------------------
`default_nettype none

module rif_front import rif_pkg::*; #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxLevel  = 5,
  parameter int unsigned RangeBits = 20,
  parameter int unsigned Depth     = 9232,
  parameter int unsigned CntW      = 21,
  localparam int unsigned AddrW    = $clog2(Depth),
  localparam int unsigned JobW     = 1 + AddrW + CntW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // [19:0] range_in
  input  wire logic                 s_axis_tuser,  // [0] command
  // Configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [10:0]          cfg_data_i,
  // Line store write port
  output logic                      st_we_o,
  output logic      [AddrW-1:0]     st_waddr_o,
  output logic      [RangeBits-1:0] st_wdata_o,
  // Job queue
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output logic      [JobW-1:0]      q_data_o,
  // Effective configuration
  output rif_cfg_t                  cfg_o
);

  localparam int unsigned CmpW     = CntW + 1;
  localparam int unsigned RstWidth = (MaxWidth < 640) ? MaxWidth : 640;
  localparam int unsigned RstTotal = RstWidth * 480;

  logic [2:0]       level_q, level_d;
  logic [10:0]      height_q, height_d;
  logic [10:0]      width_q, width_d;
  rif_cfg_t         eff_q, eff_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [13:0]      delay_q, delay_d;
  logic [2:0]       hw;
  logic             cfg_wr;

  logic [CntW-1:0]  in_cnt_q, in_cnt_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] optr_q, optr_d;

  logic             accept, is_push, frame_in, due, emit, last;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  // Next register values and the effective settings derived from them.
  always_comb begin
    level_d  = level_q;
    height_d = height_q;
    width_d  = width_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        REG_LEVEL:  level_d  = cfg_data_i[2:0];
        REG_HEIGHT: height_d = cfg_data_i;
        REG_WIDTH:  width_d  = cfg_data_i;
        default:    ;
      endcase
    end
    eff_d.level  = (level_d > 3'(MaxLevel)) ? 3'(MaxLevel) : level_d;
    eff_d.height = (height_d == 11'd0) ? 11'd1 : height_d;
    if (width_d == 11'd0) begin
      eff_d.width = 11'd1;
    end else if ({2'b00, width_d} > 13'(MaxWidth)) begin
      eff_d.width = 11'(MaxWidth);
    end else begin
      eff_d.width = width_d;
    end
    hw      = 3'(win_size(eff_d.level) >> 1);
    total_d = CntW'(22'(eff_d.width) * 22'(eff_d.height));
    delay_d = 14'(14'(hw) * 14'(eff_d.width)) + 14'(hw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= 3'd0;
      height_q     <= 11'd480;
      width_q      <= 11'd640;
      eff_q.level  <= 3'd0;
      eff_q.height <= 11'd480;
      eff_q.width  <= 11'(RstWidth);
      total_q      <= CntW'(RstTotal);
      delay_q      <= 14'd0;
    end else begin
      level_q  <= level_d;
      height_q <= height_d;
      width_q  <= width_d;
      eff_q    <= eff_d;
      total_q  <= total_d;
      delay_q  <= delay_d;
    end
  end

  assign cfg_o = eff_q;

  // Classification of the accepted transaction.
  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_push       = (s_axis_tuser == CMD_PUSH);
  assign frame_in      = (in_cnt_q >= total_q);
  assign due           = (CmpW'(in_cnt_q) + CmpW'(1)) > (CmpW'(out_cnt_q) + CmpW'(delay_q));
  assign emit          = accept && (is_push ? (!frame_in && due) : frame_in);
  assign last          = (CmpW'(out_cnt_q) + CmpW'(1)) >= CmpW'(total_q);

  assign st_we_o    = accept && is_push && !frame_in;
  assign st_waddr_o = wptr_q;
  assign st_wdata_o = RangeBits'({{RangeBits{1'b0}}, s_axis_tdata[19:0]});

  assign q_push_o = emit;
  assign q_data_o = {last, optr_q, out_cnt_q};

  // Sample and result counters with ring pointers into the line store.
  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    wptr_d    = wptr_q;
    optr_d    = optr_q;
    if (st_we_o) begin
      in_cnt_d = in_cnt_q + CntW'(1);
      wptr_d   = (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + AddrW'(1);
    end
    if (emit) begin
      out_cnt_d = out_cnt_q + CntW'(1);
      optr_d    = (optr_q == AddrW'(Depth - 1)) ? '0 : optr_q + AddrW'(1);
      if (last) begin
        in_cnt_d  = '0;
        out_cnt_d = '0;
        wptr_d    = '0;
        optr_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      wptr_q    <= '0;
      optr_q    <= '0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      wptr_q    <= wptr_d;
      optr_q    <= optr_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rif_back.sv
// ----------------------------------------------------------------------------
// rif_back
// Takes one job at a time; unless bypassed, finds the pixel position with a
// serial divider and, away from the border, scans the window through the line store and counts close neighbors.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_image_outlier_filter_macros.svh"

module rif_back import rif_pkg::*; #(
  parameter int unsigned RangeBits = 20,
  parameter int unsigned Depth     = 9232,
  parameter int unsigned CntW      = 21,
  localparam int unsigned AddrW    = $clog2(Depth),
  localparam int unsigned JobW     = 1 + AddrW + CntW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  rif_cfg_t                  cfg_i,
  // Job queue
  input  wire logic                 job_valid_i,
  input  wire logic [JobW-1:0]      job_data_i,
  output logic                      job_pop_o,
  // Line store read port
  output logic      [AddrW-1:0]     st_raddr_o,
  input  wire logic [RangeBits-1:0] st_rdata_i,
  // Result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [23:0]          m_axis_tdata,  // [19:0] range_out
  output logic                      m_axis_tlast   // last_of_frame
);

  localparam int unsigned StepW = $clog2(CntW + 1);

  rif_state_e           state_q, state_d;
  logic [CntW-1:0]      quo_q, quo_d;
  logic [11:0]          rem_q, rem_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [AddrW-1:0]     ctr_q, ctr_d;
  logic                 last_q, last_d;
  logic [RangeBits-1:0] v_q, v_d;
  logic [RangeBits-1:0] res_q, res_d;
  logic [AddrW-1:0]     row_q, row_d;
  logic [AddrW-1:0]     col_q, col_d;
  logic [3:0]           r_q, r_d;
  logic [3:0]           k_q, k_d;
  logic [6:0]           cnt_q, cnt_d;
  logic                 chk_q, chk_d;

  logic                 out_valid_q, out_valid_d;
  logic [19:0]          out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;

  logic [3:0]           ws;
  logic [2:0]           hw;
  logic [6:0]           minc;
  logic                 bypass;
  logic [11:0]          rem_sh;
  logic                 border;
  logic [AddrW:0]       off, start, row_sum, col_sum;
  logic [RangeBits-1:0] diff;
  logic [RangeBits:0]   tol;
  logic                 hit;
  logic [6:0]           cnt_hit;
  logic                 out_free;

  assign ws     = win_size(cfg_i.level);
  assign hw     = 3'(ws >> 1);
  assign minc   = min_count(cfg_i.level);
  assign bypass = (cfg_i.level == 3'd0) || (cfg_i.width < MIN_DIM) || (cfg_i.height < MIN_DIM);

  // One restoring division step: position from pixel index.
  assign rem_sh = {rem_q[10:0], quo_q[CntW-1]};

  // Border test on row quo_q and column rem_q.
  assign border = (quo_q < CntW'(hw))
               || ((CntW + 1)'(quo_q) + (CntW + 1)'(hw) >= (CntW + 1)'(cfg_i.height))
               || (rem_q < 12'(hw))
               || (rem_q + 12'(hw) >= 12'(cfg_i.width));

  // Ring address of the window's first pixel and the scan steps.
  assign off     = (AddrW + 1)'(14'(14'(hw) * 14'(cfg_i.width)) + 14'(hw));
  assign start   = ({1'b0, ctr_q} >= off) ? ({1'b0, ctr_q} - off)
                                          : ({1'b0, ctr_q} + (AddrW + 1)'(Depth) - off);
  assign row_sum = {1'b0, row_q} + (AddrW + 1)'(cfg_i.width);
  assign col_sum = {1'b0, col_q} + (AddrW + 1)'(1);

  // Closeness test of the sample returned by the store.
  assign diff    = (st_rdata_i >= v_q) ? (st_rdata_i - v_q) : (v_q - st_rdata_i);
  assign tol     = (RangeBits + 1)'(v_q >> 4) + (RangeBits + 1)'(1);
  assign hit     = ({1'b0, diff} <= tol);
  assign cnt_hit = cnt_q + 7'(chk_q && hit);

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer: next state, scan control and result.
  always_comb begin
    state_d    = state_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    step_d     = step_q;
    ctr_d      = ctr_q;
    last_d     = last_q;
    v_d        = v_q;
    res_d      = res_q;
    row_d      = row_q;
    col_d      = col_q;
    r_d        = r_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    chk_d      = 1'b0;
    job_pop_o  = 1'b0;
    st_raddr_o = col_q;
    case (state_q)
      ST_IDLE: begin
        st_raddr_o = job_data_i[CntW +: AddrW];
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          quo_d     = job_data_i[CntW-1:0];
          ctr_d     = job_data_i[CntW +: AddrW];
          last_d    = job_data_i[JobW-1];
          state_d   = ST_CENT;
        end
      end
      ST_CENT: begin
        v_d    = st_rdata_i;
        res_d  = st_rdata_i;
        rem_d  = '0;
        step_d = '0;
        state_d = bypass ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= 12'(cfg_i.width)) begin
          rem_d = rem_sh - 12'(cfg_i.width);
          quo_d = {quo_q[CntW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[CntW-2:0], 1'b0};
        end
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(CntW - 1)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        row_d = AddrW'(start);
        col_d = AddrW'(start);
        r_d   = '0;
        k_d   = '0;
        cnt_d = '0;
        state_d = border ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        chk_d = 1'b1;
        cnt_d = cnt_hit;
        if (k_q == ws - 4'd1) begin
          k_d   = '0;
          r_d   = r_q + 4'd1;
          row_d = (row_sum >= (AddrW + 1)'(Depth)) ? AddrW'(row_sum - (AddrW + 1)'(Depth))
                                                   : AddrW'(row_sum);
          col_d = row_d;
          if (r_q == ws - 4'd1) begin
            state_d = ST_TAIL;
          end
        end else begin
          k_d   = k_q + 4'd1;
          col_d = (col_sum >= (AddrW + 1)'(Depth)) ? '0 : AddrW'(col_sum);
        end
      end
      ST_TAIL: begin
        res_d   = (cnt_hit < minc) ? '0 : v_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: holds one finished result for the consumer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = 20'({{20{1'b0}}, res_q});
      out_last_d  = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    ctr_q      <= ctr_d;
    last_q     <= last_d;
    v_q        <= v_d;
    res_q      <= res_d;
    row_q      <= row_d;
    col_q      <= col_d;
    r_q        <= r_d;
    k_q        <= k_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_data_q};
  assign m_axis_tlast  = out_last_q;

  `RIF_ASSERT(a_pop_only_idle, job_pop_o |-> state_q == ST_IDLE, "job taken while busy")
  `RIF_ASSERT(a_done_loads, (state_q == ST_DONE && out_free) |=> out_valid_q, "result not loaded")
  `RIF_ASSERT_NEVER(a_scan_rows, state_q == ST_SCAN && r_q >= ws, "scan ran past the window")

endmodule

`default_nettype wire

FILE: rtl/core/range_image_outlier_filter.sv
// ----------------------------------------------------------------------------
// range_image_outlier_filter
// Nearest-neighbor outlier removal on a raster stream of Q10.10 range samples.
// ----------------------------------------------------------------------------
// The front accepts one sample or drain per clock while its two-entry job
// queue has room, and stores samples in a ring of 9*MaxWidth+16 entries.
// Each result is then produced by the back over one read port of that ring,
// one job at a time: a bypassed pixel (level 0 or image under 11 pixels in
// either direction) passes straight from its centre read to the output, a
// border pixel also goes through the serial position divider over the CntW
// bits of its index (CntW = 21 at the default width), and a filtered pixel
// then scans a ws*ws window (ws = 3, 5, 6, 7 or 9). Results leave in raster
// order; drains flush the tail of a frame. No clearing pass runs after reset.
`default_nettype none

module range_image_outlier_filter import rif_pkg::*; #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxLevel  = 5,
  parameter int unsigned RangeBits = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [19:0] range_in
  input  wire logic        s_axis_tuser,  // [0] command
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // [19:0] range_out
  output logic             m_axis_tlast,  // last_of_frame
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  localparam int unsigned Depth = 9 * MaxWidth + 16;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(MaxWidth * 2047 + 1);
  localparam int unsigned JobW  = 1 + AddrW + CntW;

  logic                 st_we;
  logic [AddrW-1:0]     st_waddr, st_raddr;
  logic [RangeBits-1:0] st_wdata, st_rdata;
  logic                 q_full, q_push, q_valid, q_pop;
  logic [JobW-1:0]      q_wdata, q_rdata;
  rif_cfg_t             eff_cfg;

  rif_front #(
    .MaxWidth (MaxWidth),
    .MaxLevel (MaxLevel),
    .RangeBits(RangeBits),
    .Depth    (Depth),
    .CntW     (CntW)
  ) u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .st_we_o   (st_we),
    .st_waddr_o(st_waddr),
    .st_wdata_o(st_wdata),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata),
    .cfg_o     (eff_cfg)
  );

  rif_ram #(
    .Width(RangeBits),
    .Depth(Depth)
  ) u_line_store (
    .clk_i,
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  rif_queue #(
    .Width(JobW)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  rif_back #(
    .RangeBits(RangeBits),
    .Depth    (Depth),
    .CntW     (CntW)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (eff_cfg),
    .job_valid_i(q_valid),
    .job_data_i (q_rdata),
    .job_pop_o  (q_pop),
    .st_raddr_o (st_raddr),
    .st_rdata_i (st_rdata),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

endmodule

`default_nettype wire

FILE: test/tb_range_image_outlier_filter.sv
// ----------------------------------------------------------------------------
// Testbench for range_image_outlier_filter
// Streams depth frames through the filter under random flow control on both
// sides and checks every result against a local model of the window filter.
// A short table of directed items comes first. Random frames follow over
// several settings of level, height and width, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_range_image_outlier_filter;
  import rif_pkg::*;

  localparam int unsigned MAX_W       = 1024;
  localparam int unsigned STORE_DEPTH = 9 * MAX_W + 16;
  localparam int unsigned SETTLE      = 300;
  localparam int unsigned LIMIT       = 3000000;
  localparam int unsigned N_PHASES    = 12;

  // One row of the directed table. A config row writes register idx.
  typedef struct packed {
    bit        is_cfg;
    bit [1:0]  idx;
    bit        cmd;
    bit [19:0] data;
    bit        has_exp;
    bit [19:0] exp_range;
    bit        exp_last;
  } dir_row_t;

  typedef struct packed {
    logic [19:0] range_val;
    logic        last;
  } pixel_res_t;

  localparam dir_row_t DIR_TAB [0:24] = '{
    // Level 0 on a 3x2 image: each sample comes straight back.
    '{1'b1, REG_LEVEL,  CMD_PUSH,  20'd0,       1'b0, 20'h0,     1'b0},
    '{1'b1, REG_HEIGHT, CMD_PUSH,  20'd2,       1'b0, 20'h0,     1'b0},
    '{1'b1, REG_WIDTH,  CMD_PUSH,  20'd3,       1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h00000,   1'b1, 20'h00000, 1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'hFFFFF,   1'b1, 20'hFFFFF, 1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h55555,   1'b1, 20'h55555, 1'b0},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'hFFFFF,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'hAAAAA,   1'b1, 20'hAAAAA, 1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h12345,   1'b1, 20'h12345, 1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h0F0F0,   1'b1, 20'h0F0F0, 1'b1},
    // Saturated level on the small image: the delay outlasts the frame,
    // an extra push is dropped and drains flush all six pixels unchanged.
    '{1'b1, REG_LEVEL,  CMD_PUSH,  20'd7,       1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h80000,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h7FFFF,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h00001,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'hFFFFE,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h3C3C3,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'hC3C3C,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_PUSH,  20'h11111,   1'b0, 20'h0,     1'b0},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'h0,       1'b1, 20'h80000, 1'b0},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'h0,       1'b1, 20'h7FFFF, 1'b0},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'h0,       1'b1, 20'h00001, 1'b0},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'h0,       1'b1, 20'hFFFFE, 1'b0},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'h0,       1'b1, 20'h3C3C3, 1'b0},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'h0,       1'b1, 20'hC3C3C, 1'b1},
    '{1'b0, 2'd0,       CMD_DRAIN, 20'h0,       1'b0, 20'h0,     1'b0}
  };

  // Random phases: level, height, width. Small frames carry the filtering,
  // the large ones check the clamps and the pass-through path.
  localparam int unsigned PH_LEVEL  [0:N_PHASES-1] = '{1, 2, 3, 4, 5, 7, 6, 0, 5, 2, 3, 1};
  localparam int unsigned PH_HEIGHT [0:N_PHASES-1] = '{11, 12, 11, 13, 11, 12, 11, 1, 1024,
                                                        10, 11, 0};
  localparam int unsigned PH_WIDTH  [0:N_PHASES-1] = '{11, 13, 14, 11, 11, 12, 12, 2047, 0,
                                                        11, 10, 5};

  localparam int unsigned WIN_EDGE [0:5] = '{0, 3, 5, 6, 7, 9};
  localparam int unsigned MIN_HITS [0:5] = '{0, 3, 5, 5, 7, 11};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [10:0] cfg_data_i;

  // Local copy of the filter state.
  logic [19:0] sample_ring [STORE_DEPTH];
  int unsigned level_q, height_q, width_q;
  int unsigned pushed_cnt, emitted_cnt;

  pixel_res_t  pending_pixels [$];
  int unsigned errors, n_items, n_results, n_zeroed, n_last, cycles;
  bit          calm;
  int unsigned stall_left;

  range_image_outlier_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Effective geometry and level after the clamps.
  function automatic int unsigned eff_width();
    if (width_q == 0) return 1;
    if (width_q > MAX_W) return MAX_W;
    return width_q;
  endfunction

  function automatic int unsigned eff_height();
    return (height_q == 0) ? 1 : height_q;
  endfunction

  function automatic int unsigned eff_level();
    return (level_q > 5) ? 5 : level_q;
  endfunction

  // Filtered value of pixel c, using only stored input samples.
  function automatic logic [19:0] filtered_pixel(int unsigned c);
    int unsigned w, h, l, ws, hw, y, x, hits, base;
    logic [19:0] v, s;
    int          diff, tol;
    w = eff_width();
    h = eff_height();
    l = eff_level();
    v = sample_ring[c % STORE_DEPTH];
    if (l == 0 || w < 11 || h < 11) return v;
    ws = WIN_EDGE[l];
    hw = ws / 2;
    y = c / w;
    x = c % w;
    if (y < hw || y + hw >= h || x < hw || x + hw >= w) return v;
    tol = 1 + int'(v >> 4);
    hits = 0;
    for (int unsigned r = 0; r < ws; r++) begin
      base = (y - hw + r) * w + (x - hw);
      for (int unsigned k = 0; k < ws; k++) begin
        s = sample_ring[(base + k) % STORE_DEPTH];
        diff = int'(s) - int'(v);
        if (diff < 0) diff = -diff;
        if (diff <= tol) hits++;
      end
    end
    return (hits < MIN_HITS[l]) ? 20'd0 : v;
  endfunction

  // Next pixel of the output raster; closes the frame on its last pixel.
  function automatic pixel_res_t next_output();
    pixel_res_t res;
    res.range_val = filtered_pixel(emitted_cnt);
    res.last = (emitted_cnt + 1 >= eff_width() * eff_height());
    emitted_cnt++;
    if (res.last) begin
      pushed_cnt = 0;
      emitted_cnt = 0;
    end
    return res;
  endfunction

  // Effect of one accepted item on the local state.
  function automatic bit filter_step(input logic cmd, input logic [19:0] val,
                                     output pixel_res_t res);
    int unsigned total, hw, delay;
    total = eff_width() * eff_height();
    hw = WIN_EDGE[eff_level()] / 2;
    delay = hw * eff_width() + hw;
    res = '0;
    if (cmd == CMD_PUSH) begin
      if (pushed_cnt >= total) return 1'b0;
      sample_ring[pushed_cnt % STORE_DEPTH] = val;
      pushed_cnt++;
      if (pushed_cnt > emitted_cnt + delay) begin
        res = next_output();
        return 1'b1;
      end
      return 1'b0;
    end
    if (pushed_cnt >= total) begin
      res = next_output();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one item; valid stays high after acceptance so that back-to-back
  // items need no second assignment in the same step.
  task automatic send_item(input logic cmd, input logic [19:0] val,
                           input bit typed, input pixel_res_t typed_res);
    int unsigned gap;
    bit          got;
    pixel_res_t  res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, val};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    got = filter_step(cmd, val, res);
    if (typed) begin
      got = 1'b1;
      res = typed_res;
    end
    if (got) pending_pixels.push_back(res);
  endtask

  // Holds the sender until every expected result has come out.
  task automatic drain_pending();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    drain_pending();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[10:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LEVEL:  level_q  = val & 32'h7;
      REG_HEIGHT: height_q = val & 32'h7FF;
      REG_WIDTH:  width_q  = val & 32'h7FF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Sample near the frame's base value, within about one tolerance, or noise.
  function automatic logic [19:0] frame_sample(logic [19:0] base, int unsigned near_pct);
    int          tol, v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < near_pct) begin
      tol = 1 + int'(base >> 4);
      v = int'(base) + int'($urandom_range(0, 2 * tol + 2)) - (tol + 1);
      if (v < 0) v = 0;
      if (v > 20'hFFFFF) v = 20'hFFFFF;
      return v[19:0];
    end
    if (r < near_pct + 4) return 20'h00000;
    if (r < near_pct + 8) return 20'hFFFFF;
    return $urandom_range(0, 20'hFFFFF);
  endfunction

  // One whole frame: pushes with a few stray drains, then the flush.
  task automatic run_frame(input bit pause_midway);
    int unsigned total, near_pct;
    logic [19:0] base;
    total = eff_width() * eff_height();
    near_pct = $urandom_range(20, 90);
    base = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 40))
                                       : 20'($urandom_range(0, 20'hFFFFF));
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 99) < 4)
        send_item(CMD_DRAIN, 20'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
      if (pause_midway && i == total / 2) drain_pending();
      send_item(CMD_PUSH, frame_sample(base, near_pct), 1'b0, '0);
    end
    while (pushed_cnt != 0 && pushed_cnt >= total) begin
      if ($urandom_range(0, 99) < 15)
        send_item(CMD_PUSH, 20'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
      else
        send_item(CMD_DRAIN, 20'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
    end
    // A drain at the start of the next frame has nothing to flush.
    send_item(CMD_DRAIN, 20'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
  endtask

  // Result checker: each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    pixel_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tdata[19:0] == 20'd0) n_zeroed++;
      if (m_axis_tlast) n_last++;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result range=%h last=%b", $time,
                 m_axis_tdata[19:0], m_axis_tlast);
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[19:0] !== want.range_val) begin
          errors++;
          $display("%0t: range_out expected %h got %h", $time, want.range_val,
                   m_axis_tdata[19:0]);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: last_of_frame expected %b got %b", $time, want.last,
                   m_axis_tlast);
        end
      end
    end
  end

  // Receiver flow control: random stalls, mostly short, some long.
  always @(posedge clk_i) begin
    int unsigned r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_range_image_outlier_filter NOT OK");
      $finish;
    end
  end

  initial begin
    pixel_res_t typed_res;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    errors = 0; n_items = 0; n_results = 0; n_zeroed = 0; n_last = 0;
    cycles = 0; stall_left = 0; calm = 1'b0;
    level_q = 0; height_q = 480; width_q = 640;
    pushed_cnt = 0; emitted_cnt = 0;
    for (int unsigned i = 0; i < STORE_DEPTH; i++) sample_ring[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].is_cfg) begin
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
      end else begin
        typed_res.range_val = DIR_TAB[i].exp_range;
        typed_res.last = DIR_TAB[i].exp_last;
        send_item(DIR_TAB[i].cmd, DIR_TAB[i].data, DIR_TAB[i].has_exp, typed_res);
      end
    end

    // Random frames over each setting; some frames run without idling.
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      write_reg(REG_LEVEL, PH_LEVEL[p]);
      write_reg(REG_HEIGHT, PH_HEIGHT[p]);
      write_reg(REG_WIDTH, PH_WIDTH[p]);
      calm = ($urandom_range(0, 3) == 0);
      run_frame(p == 0);
      calm = 1'b0;
    end

    drain_pending();
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d items over %0d settings: %0d results, %0d frames closed,",
             n_items, N_PHASES + 2, n_results, n_last);
    $display("%0d results zero (outliers or zero samples), %0d mismatches.",
             n_zeroed, errors);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("tb_range_image_outlier_filter OK");
    end else begin
      $display("tb_range_image_outlier_filter NOT OK");
    end
    $finish;
  end

endmodule
